[sv/srlf_pkg.sv]
package srlf_pkg;

   localparam int PIXEL_W    = 8;
   localparam int TAU_W      = 6;
   localparam int SIZE_W     = 11;
   localparam int LEVEL_W    = 8;
   localparam int CFG_IDX_W  = 3;
   localparam int CFG_DATA_W = 11;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;
   localparam int TAU_MAX_DEF    = 63;

   // register indexes on the csr port
   localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_TAU_START    = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_TAU_FINAL    = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_MARK_LEVEL   = 3'd4;

   localparam logic [SIZE_W-1:0]  IMAGE_WIDTH_RST  = 11'd640;
   localparam logic [SIZE_W-1:0]  IMAGE_HEIGHT_RST = 11'd480;
   localparam logic [TAU_W-1:0]   TAU_START_RST    = 6'd5;
   localparam logic [TAU_W-1:0]   TAU_FINAL_RST    = 6'd20;
   localparam logic [LEVEL_W-1:0] MARK_LEVEL_RST   = 8'd40;

   typedef struct packed {
      logic             start;
      logic [TAU_W-1:0] tau_start;
      logic [TAU_W-1:0] tau_final;
   } tau_req_type;

   typedef struct packed {
      logic             done;
      logic [TAU_W-1:0] tau;
   } tau_rsp_type;

   typedef struct packed {
      logic               rd_en;
      logic               force_zero;
      logic [PIXEL_W-1:0] right_pix;
   } filt_req_type;

endpackage

[sv/srlf_line_filter.sv]
module srlf_line_filter #(
   parameter int MAX_WIDTH = srlf_pkg::MAX_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]        wr_addr,
   input  logic [srlf_pkg::PIXEL_W-1:0]        wr_data,
   input  srlf_pkg::filt_req_type              req,
   input  logic [$clog2(MAX_WIDTH)-1:0]        ctr_addr,
   input  logic [$clog2(MAX_WIDTH)-1:0]        left_addr,
   output logic [srlf_pkg::PIXEL_W-1:0]        value
);

   localparam int PW = srlf_pkg::PIXEL_W;

   logic [PW-1:0] line_mem [MAX_WIDTH];

   logic [PW-1:0] ctr_ff;
   logic [PW-1:0] left_ff;
   logic [PW-1:0] right_ff;
   logic          zero_ff;

   logic [PW-1:0]   peak;
   logic signed [PW:0] diff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
      if (req.rd_en) begin
         ctr_ff   <= line_mem[ctr_addr];
         left_ff  <= line_mem[left_addr];
         right_ff <= req.right_pix;
         zero_ff  <= req.force_zero;
      end
   end

   // 2c - l - r - |l - r| == 2 * (c - max(l, r)); a zero centre lands at or below 0
   always_comb begin
      peak = (left_ff > right_ff) ? left_ff : right_ff;
      diff = $signed({1'b0, ctr_ff}) - $signed({1'b0, peak});
      if (zero_ff || diff[PW]) begin
         value = '0;
      end else if (diff[PW-1]) begin
         value = '1;
      end else begin
         value = {diff[PW-2:0], 1'b0};
      end
   end

endmodule

[sv/srlf_tau_unit.sv]
module srlf_tau_unit #(
   parameter int MAX_HEIGHT = srlf_pkg::MAX_HEIGHT_DEF,
   parameter int TAU_MAX    = srlf_pkg::TAU_MAX_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  srlf_pkg::tau_req_type             req,
   input  logic [$clog2(MAX_HEIGHT)-1:0]     row_idx,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]   height,
   output srlf_pkg::tau_rsp_type             rsp
);

   localparam int TW     = srlf_pkg::TAU_W;
   localparam int HW     = $clog2(MAX_HEIGHT + 1);
   localparam int SW     = HW + 2;
   localparam int NW     = HW + TW + 4;
   localparam int QW     = HW + TW;
   localparam int STEP_W = $clog2(TW);

   typedef enum logic [1:0] {
      T_IDLE,
      T_SUM,
      T_DIV
   } tau_state_type;

   tau_state_type         state_ff;
   srlf_pkg::tau_rsp_type rsp_ff;

   logic signed [NW-1:0] prod_a_ff;
   logic signed [NW-1:0] prod_b_ff;
   logic [HW-1:0]        h_ff;
   logic [TW-1:0]        ts_ff;
   logic                 low_ff;
   logic [QW-1:0]        rem_ff;
   logic [TW-1:0]        q_ff;
   logic [STEP_W-1:0]    step_ff;

   logic [SW-1:0]        twice_j;
   logic signed [SW-1:0] span;
   logic signed [TW:0]   dtau;
   logic                 low_half;
   logic signed [NW-1:0] num;
   logic signed [NW-1:0] lim;
   logic [QW-1:0]        trial;
   logic                 q_bit;
   logic [TW-1:0]        q_next;

   function automatic logic [TW-1:0] clamp_tau(input logic [TW-1:0] t);
      if (32'(t) > TAU_MAX) begin
         return TW'(TAU_MAX);
      end
      return t;
   endfunction

   always_comb begin
      twice_j  = SW'({row_idx, 1'b0});
      span     = $signed(twice_j) - $signed(SW'(height));
      low_half = twice_j <= SW'(height);
      dtau     = $signed({1'b0, req.tau_final}) - $signed({1'b0, req.tau_start});
      num      = prod_a_ff + prod_b_ff;
      lim      = $signed(NW'({h_ff, {TW{1'b0}}}));
      trial    = QW'(h_ff) << step_ff;
      q_bit    = rem_ff >= trial;
      q_next   = {q_ff[TW-2:0], q_bit};
   end

   // rows past the middle: num = ts*h + (tf - ts)*(2j - h); quotient by h,
   // one bit a cycle, after the saturation test against 64*h
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         rsp_ff   <= '0;
      end else begin
         rsp_ff.done <= 1'b0;
         unique case (state_ff)
            T_IDLE: begin
               if (req.start) begin
                  prod_a_ff <= $signed(NW'(req.tau_start) * NW'(height));
                  prod_b_ff <= NW'(dtau) * NW'(span);
                  h_ff      <= height;
                  ts_ff     <= clamp_tau(req.tau_start);
                  low_ff    <= low_half;
                  state_ff  <= T_SUM;
               end
            end
            T_SUM: begin
               if (low_ff) begin
                  rsp_ff   <= '{done: 1'b1, tau: ts_ff};
                  state_ff <= T_IDLE;
               end else if (num < 0) begin
                  rsp_ff   <= '{done: 1'b1, tau: '0};
                  state_ff <= T_IDLE;
               end else if (num >= lim) begin
                  rsp_ff   <= '{done: 1'b1, tau: TW'(TAU_MAX)};
                  state_ff <= T_IDLE;
               end else begin
                  rem_ff   <= QW'(num);
                  q_ff     <= '0;
                  step_ff  <= STEP_W'(TW - 1);
                  state_ff <= T_DIV;
               end
            end
            T_DIV: begin
               if (q_bit) begin
                  rem_ff <= rem_ff - trial;
               end
               q_ff <= q_next;
               if (step_ff == '0) begin
                  rsp_ff   <= '{done: 1'b1, tau: clamp_tau(q_next)};
                  state_ff <= T_IDLE;
               end else begin
                  step_ff <= step_ff - STEP_W'(1);
               end
            end
            default: begin
               state_ff <= T_IDLE;
            end
         endcase
      end
   end

   assign rsp = rsp_ff;

   a_tau_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.done |-> 32'(rsp_ff.tau) <= TAU_MAX)
      else $error("row tau above its limit");

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> state_ff == T_IDLE)
      else $error("tau request while a division runs");

endmodule

[sv/step_row_lane_filter.sv]
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    req_pixel
// rsp      out        rsp_valid/rsp_ready    rsp_column, rsp_filtered, rsp_mark, rsp_row_end
// csr      in         csr_valid/csr_ready    csr_index, csr_data (csr_ready always high)
//
// A pixel inside a row passes through accept with line store write and reads,
// response from the registered read data, then the result load.
// The first pixel of a row also waits for the row tau; a row below the middle may
// also need a division in the tau unit (one quotient bit per cycle).
// The last pixel of a row emits its tail columns in turn, up to tau + 1 results.
// A stalled rsp holds the sequencer in its emit state; req_ready is low meanwhile.
// Synchronous active-high reset; the line store is not cleared.
module step_row_lane_filter #(
   parameter int MAX_WIDTH  = srlf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = srlf_pkg::MAX_HEIGHT_DEF,
   parameter int TAU_MAX    = srlf_pkg::TAU_MAX_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [srlf_pkg::PIXEL_W-1:0]        req_pixel,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [$clog2(MAX_WIDTH)-1:0]        rsp_column,
   output logic [srlf_pkg::PIXEL_W-1:0]        rsp_filtered,
   output logic                                rsp_mark,
   output logic                                rsp_row_end,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [srlf_pkg::CFG_IDX_W-1:0]      csr_index,
   input  logic [srlf_pkg::CFG_DATA_W-1:0]     csr_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int TW = srlf_pkg::TAU_W;
   localparam int PW = srlf_pkg::PIXEL_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_TAU,
      S_CALC,
      S_EMIT
   } seq_state_type;

   seq_state_type state_ff;

   logic [srlf_pkg::SIZE_W-1:0]  width_cfg_ff;
   logic [srlf_pkg::SIZE_W-1:0]  height_cfg_ff;
   logic [TW-1:0]                tau_start_ff;
   logic [TW-1:0]                tau_final_ff;
   logic [srlf_pkg::LEVEL_W-1:0] level_ff;

   logic [CW-1:0] col_cnt_ff;
   logic [RW-1:0] row_cnt_ff;
   logic [TW-1:0] row_tau_ff;
   logic [CW-1:0] item_col_ff;
   logic          item_last_ff;
   logic          has_res_ff;
   logic [CW-1:0] emit_c_ff;
   logic [PW-1:0] emit_val_ff;

   logic          rsp_valid_ff;
   logic [CW-1:0] rsp_column_ff;
   logic [PW-1:0] rsp_filtered_ff;
   logic          rsp_mark_ff;
   logic          rsp_row_end_ff;

   logic [WW-1:0] eff_w;
   logic [HW-1:0] eff_h;
   logic [WW-1:0] half_w;
   logic [WW-1:0] col_w;
   logic [WW-1:0] tau_w;
   logic [TW-1:0] tau_now;
   logic [TW-1:0] tau_new;
   logic          at_last;
   logic          has_res_now;
   logic          zero_now;
   logic          accept;
   logic          rsp_load;
   logic          row_end_now;
   logic [CW-1:0] col_cnt_in;
   logic [RW-1:0] row_cnt_in;
   logic [CW-1:0] first_c;
   logic [CW-1:0] ctr_addr;
   logic [CW-1:0] left_addr;
   logic [PW-1:0] filt_value;

   srlf_pkg::tau_req_type  tau_req;
   srlf_pkg::tau_rsp_type  tau_rsp;
   srlf_pkg::filt_req_type filt_req;

   function automatic logic [TW-1:0] clamp_half(input logic [TW-1:0] t,
                                                input logic [WW-1:0] half);
      if (32'(t) > 32'(half)) begin
         return TW'(half);
      end
      return t;
   endfunction

   always_comb begin
      if (width_cfg_ff == '0) begin
         eff_w = WW'(1);
      end else if (32'(width_cfg_ff) > 32'(MAX_WIDTH)) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(width_cfg_ff);
      end
      if (height_cfg_ff == '0) begin
         eff_h = HW'(1);
      end else if (32'(height_cfg_ff) > 32'(MAX_HEIGHT)) begin
         eff_h = HW'(MAX_HEIGHT);
      end else begin
         eff_h = HW'(height_cfg_ff);
      end
      half_w  = eff_w >> 1;
      col_w   = WW'(col_cnt_ff);
      at_last = (col_w + WW'(1)) >= eff_w;
      tau_now = clamp_half(row_tau_ff, half_w);
      tau_new = clamp_half(tau_rsp.tau, half_w);
      tau_w   = WW'(tau_now);

      has_res_now = at_last || (col_w >= tau_w);
      // centre too close to either edge; tau of 0 always gives 0 (l = r = c)
      zero_now    = (col_w < (tau_w << 1)) || (col_w >= eff_w) || (tau_now == '0);
      first_c     = (col_w >= tau_w) ? CW'(col_w - tau_w) : '0;
      ctr_addr    = CW'(col_w - tau_w);
      left_addr   = CW'(col_w - (tau_w << 1));

      col_cnt_in = at_last ? '0 : CW'(col_w + WW'(1));
      if (!at_last) begin
         row_cnt_in = row_cnt_ff;
      end else if ((HW'(row_cnt_ff) + HW'(1)) >= eff_h) begin
         row_cnt_in = '0;
      end else begin
         row_cnt_in = row_cnt_ff + RW'(1);
      end

      accept      = req_valid && (state_ff == S_IDLE);
      rsp_load    = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ready);
      row_end_now = item_last_ff && (emit_c_ff == item_col_ff);

      tau_req.start     = accept && (col_cnt_ff == '0);
      tau_req.tau_start = tau_start_ff;
      tau_req.tau_final = tau_final_ff;

      filt_req.rd_en      = accept && (col_cnt_ff != '0);
      filt_req.force_zero = zero_now;
      filt_req.right_pix  = req_pixel;
   end

   srlf_tau_unit #(
      .MAX_HEIGHT (MAX_HEIGHT),
      .TAU_MAX    (TAU_MAX)
   ) u_tau (
      .clock   (clock),
      .reset   (reset),
      .req     (tau_req),
      .row_idx (row_cnt_ff),
      .height  (eff_h),
      .rsp     (tau_rsp)
   );

   srlf_line_filter #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_filter (
      .clock     (clock),
      .wr_en     (accept),
      .wr_addr   (col_cnt_ff),
      .wr_data   (req_pixel),
      .req       (filt_req),
      .ctr_addr  (ctr_addr),
      .left_addr (left_addr),
      .value     (filt_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= srlf_pkg::IMAGE_WIDTH_RST;
         height_cfg_ff <= srlf_pkg::IMAGE_HEIGHT_RST;
         tau_start_ff  <= srlf_pkg::TAU_START_RST;
         tau_final_ff  <= srlf_pkg::TAU_FINAL_RST;
         level_ff      <= srlf_pkg::MARK_LEVEL_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            srlf_pkg::REG_IMAGE_WIDTH:  width_cfg_ff  <= csr_data;
            srlf_pkg::REG_IMAGE_HEIGHT: height_cfg_ff <= csr_data;
            srlf_pkg::REG_TAU_START:    tau_start_ff  <= csr_data[TW-1:0];
            srlf_pkg::REG_TAU_FINAL:    tau_final_ff  <= csr_data[TW-1:0];
            srlf_pkg::REG_MARK_LEVEL:   level_ff      <= csr_data[srlf_pkg::LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         col_cnt_ff   <= '0;
         row_cnt_ff   <= '0;
         row_tau_ff   <= srlf_pkg::TAU_START_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  col_cnt_ff   <= col_cnt_in;
                  row_cnt_ff   <= row_cnt_in;
                  item_col_ff  <= col_cnt_ff;
                  item_last_ff <= at_last;
                  has_res_ff   <= has_res_now;
                  emit_c_ff    <= first_c;
                  state_ff     <= (col_cnt_ff == '0) ? S_TAU : S_CALC;
               end
            end
            S_TAU: begin
               // every result of column 0 is an edge result
               if (tau_rsp.done) begin
                  row_tau_ff  <= tau_rsp.tau;
                  emit_c_ff   <= '0;
                  emit_val_ff <= '0;
                  state_ff    <= (item_last_ff || tau_new == '0) ? S_EMIT : S_IDLE;
               end
            end
            S_CALC: begin
               emit_val_ff <= filt_value;
               state_ff    <= has_res_ff ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
               if (rsp_load) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_column_ff   <= emit_c_ff;
                  rsp_filtered_ff <= emit_val_ff;
                  rsp_mark_ff     <= emit_val_ff > level_ff;
                  rsp_row_end_ff  <= row_end_now;
                  if (item_last_ff && !row_end_now) begin
                     // tail columns past the last full neighborhood are all zero
                     emit_c_ff   <= emit_c_ff + CW'(1);
                     emit_val_ff <= '0;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready    = (state_ff == S_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_column   = rsp_column_ff;
   assign rsp_filtered = rsp_filtered_ff;
   assign rsp_mark     = rsp_mark_ff;
   assign rsp_row_end  = rsp_row_end_ff;

   a_tau_only_when_waiting: assert property (@(posedge clock) disable iff (reset)
      tau_rsp.done |-> state_ff == S_TAU)
      else $error("row tau arrived outside the tau wait");

   a_row_start_gets_tau: assert property (@(posedge clock) disable iff (reset)
      (accept && col_cnt_ff == '0) |=> state_ff == S_TAU)
      else $error("row start did not wait for its tau");

   a_row_end_closes_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && row_end_now) |=> (col_cnt_ff == '0 && state_ff == S_IDLE))
      else $error("row end result without column wrap");

endmodule

[tb/sv/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import srlf_pkg::*;

   localparam int COL_W         = $clog2(MAX_WIDTH_DEF);
   localparam int STIM_ITEMS    = 210;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 20;
   localparam int QUIET_LIMIT   = 3000;

   // indexes past the register list, writes there must be ignored
   localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
   localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [COL_W-1:0]   column;
      logic [PIXEL_W-1:0] filtered;
      logic               mark;
      logic               row_end;
   } lane_result_t;

   class lane_filter_board;
      logic [SIZE_W-1:0]  width_reg;
      logic [SIZE_W-1:0]  height_reg;
      logic [TAU_W-1:0]   tau_top;
      logic [TAU_W-1:0]   tau_bottom;
      logic [LEVEL_W-1:0] level_reg;
      logic [PIXEL_W-1:0] line_buf [MAX_WIDTH_DEF];
      int unsigned        col_cnt;
      int unsigned        row_cnt;
      int unsigned        row_tau;
      lane_result_t       due [$];
      int                 errors, n_pixels, n_results, n_rows, n_marks, max_tau, max_burst;

      function new();
         width_reg  = IMAGE_WIDTH_RST;
         height_reg = IMAGE_HEIGHT_RST;
         tau_top    = TAU_START_RST;
         tau_bottom = TAU_FINAL_RST;
         level_reg  = MARK_LEVEL_RST;
         col_cnt    = 0;
         row_cnt    = 0;
         row_tau    = TAU_START_RST;
         errors     = 0;
         n_pixels   = 0;
         n_results  = 0;
         n_rows     = 0;
         n_marks    = 0;
         max_tau    = 0;
         max_burst  = 0;
      endfunction

      function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
         case (idx)
            REG_IMAGE_WIDTH:  width_reg  = data[SIZE_W-1:0];
            REG_IMAGE_HEIGHT: height_reg = data[SIZE_W-1:0];
            REG_TAU_START:    tau_top    = data[TAU_W-1:0];
            REG_TAU_FINAL:    tau_bottom = data[TAU_W-1:0];
            REG_MARK_LEVEL:   level_reg  = data[LEVEL_W-1:0];
            default: ;
         endcase
      endfunction

      function int eff_width();
         if (width_reg == 0) return 1;
         if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
         return width_reg;
      endfunction

      function int eff_height();
         if (height_reg == 0) return 1;
         if (height_reg > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
         return height_reg;
      endfunction

      // pixels needed to close the open row, 0 when at a row start
      function int rest_of_row();
         if (col_cnt == 0) return 0;
         if (col_cnt + 1 >= eff_width()) return 1;
         return eff_width() - col_cnt;
      endfunction

      // tau holds over the upper half, then ramps linearly to tau_bottom
      function int row_tau_for(int unsigned j, int h);
         longint hh, jj, ts, tf, num, t;
         hh = h;
         jj = j;
         ts = tau_top;
         tf = tau_bottom;
         if (2 * jj <= hh) t = ts;
         else begin
            num = ts * hh + (tf - ts) * (2 * jj - hh);
            if (num < 0) num = 0;
            t = num / hh;
         end
         if (t > TAU_MAX_DEF) t = TAU_MAX_DEF;
         return int'(t);
      endfunction

      function int filter_response(int c, int tau, int w, int col);
         int l, r, ctr, d, v;
         if (c < tau || c + tau >= w || c + tau > col) return 0;
         ctr = line_buf[c];
         if (ctr == 0) return 0;
         l = line_buf[c - tau];
         r = line_buf[c + tau];
         d = (l > r) ? l - r : r - l;
         v = 2 * ctr - l - r - d;
         if (v < 0) v = 0;
         if (v > 255) v = 255;
         return v;
      endfunction

      function void push_result(int c, int val, bit at_end);
         lane_result_t res;
         res.column   = c[COL_W-1:0];
         res.filtered = val[PIXEL_W-1:0];
         res.mark     = (val > int'(level_reg));
         res.row_end  = at_end;
         due.push_back(res);
      endfunction

      function void note_pixel(logic [PIXEL_W-1:0] pix);
         int w, h, col, tau, c, tail_lo;
         w   = eff_width();
         h   = eff_height();
         col = col_cnt;
         if (col == 0) row_tau = row_tau_for(row_cnt, h);
         tau = row_tau;
         if (tau > w / 2) tau = w / 2;
         if (col >= MAX_WIDTH_DEF) col = MAX_WIDTH_DEF - 1;
         line_buf[col] = pix;
         n_pixels++;
         if (tau > max_tau) max_tau = tau;
         if (col + 1 < w) begin
            if (col >= tau) push_result(col - tau, filter_response(col - tau, tau, w, col), 1'b0);
            col_cnt = col + 1;
         end else begin
            // last pixel flushes every column still waiting on its right neighbour
            tail_lo = (col >= tau) ? col - tau : 0;
            for (c = tail_lo; c <= col; c++)
               push_result(c, filter_response(c, tau, w, col), c == col);
            if (col - tail_lo + 1 > max_burst) max_burst = col - tail_lo + 1;
            col_cnt = 0;
            row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
            n_rows++;
         end
      endfunction

      function void compare_field(string name, int col, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: column %0d %s mismatch: expected %0d, got %0d",
                     $time, col, name, want, got);
         end
      endfunction

      function void check_result(lane_result_t got);
         lane_result_t want;
         n_results++;
         if (got.mark) n_marks++;
         if (due.size() == 0) begin
            errors++;
            $display("%0t: result with nothing due: expected none, got column %0d filtered %0d",
                     $time, got.column, got.filtered);
            return;
         end
         want = due.pop_front();
         compare_field("column", want.column, want.column, got.column);
         compare_field("filtered", want.column, want.filtered, got.filtered);
         compare_field("mark", want.column, want.mark, got.mark);
         compare_field("row_end", want.column, want.row_end, got.row_end);
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [PIXEL_W-1:0]     req_pixel = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [COL_W-1:0]       rsp_column;
   logic [PIXEL_W-1:0]     rsp_filtered;
   logic                   rsp_mark;
   logic                   rsp_row_end;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CFG_IDX_W-1:0]   csr_index = '0;
   logic [CFG_DATA_W-1:0]  csr_data = '0;

   lane_filter_board board = new();
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;
   bit hold_off_req = 1'b0;
   int pixels_sent = 0;

   // width 6, height 4, tau 1 then clamped to 3 on the last row
   logic [PIXEL_W-1:0] probe_pix [24] = '{
      8'd0,   8'd255, 8'd0,   8'd255, 8'd255, 8'd0,
      8'd255, 8'd1,   8'd254, 8'd128, 8'd128, 8'd255,
      8'd10,  8'd200, 8'd10,  8'd60,  8'd0,   8'd60,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
   };

   step_row_lane_filter i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_pixel    (req_pixel),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_column   (rsp_column),
      .rsp_filtered (rsp_filtered),
      .rsp_mark     (rsp_mark),
      .rsp_row_end  (rsp_row_end),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CFG_DATA_W'(data);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_pixel(input logic [PIXEL_W-1:0] pix);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= pix;
      do @(posedge clock); while (!req_ready);
      pixels_sent++;
   endtask

   function automatic logic [PIXEL_W-1:0] lane_pixel(bit on_stripe);
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 8'd0;
      if (r == 1) return 8'd255;
      if (on_stripe) return 8'($urandom_range(150, 255));
      return 8'($urandom_range(0, 70));
   endfunction

   // dark road with one bright stripe, or plain noise
   task automatic send_pixels(input int n, input bit noise);
      int lo, hi, k, pos;
      lo = $urandom_range(0, 24);
      hi = lo + $urandom_range(0, 5);
      for (k = 0; k < n; k++) begin
         pos = k % 32;
         if (noise) send_pixel(8'($urandom));
         else send_pixel(lane_pixel(pos >= lo && pos <= hi));
      end
   endtask

   // stop offering, wait out every due result, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic int unsigned tau_word();
      int unsigned t;
      case ($urandom_range(0, 7))
         0:       t = 0;
         1:       t = TAU_MAX_DEF;
         default: t = $urandom_range(0, 12);
      endcase
      return ($urandom_range(0, 31) << TAU_W) | t;
   endfunction

   task automatic pick_config();
      int unsigned lvl;
      if ($urandom_range(0, 3) != 0) begin
         case ($urandom_range(0, 9))
            0:       write_reg(REG_IMAGE_WIDTH, 0);
            1:       write_reg(REG_IMAGE_WIDTH, 1);
            2:       write_reg(REG_IMAGE_WIDTH, 2);
            default: write_reg(REG_IMAGE_WIDTH, $urandom_range(3, 40));
         endcase
      end
      if ($urandom_range(0, 3) != 0) begin
         case ($urandom_range(0, 9))
            0:       write_reg(REG_IMAGE_HEIGHT, 0);
            1:       write_reg(REG_IMAGE_HEIGHT, 2047);
            default: write_reg(REG_IMAGE_HEIGHT, $urandom_range(1, 6));
         endcase
      end
      if ($urandom_range(0, 3) != 0) write_reg(REG_TAU_START, tau_word());
      if ($urandom_range(0, 3) != 0) write_reg(REG_TAU_FINAL, tau_word());
      if ($urandom_range(0, 3) != 0) begin
         case ($urandom_range(0, 5))
            0:       lvl = 0;
            1:       lvl = 255;
            default: lvl = $urandom_range(0, 255);
         endcase
         write_reg(REG_MARK_LEVEL, ($urandom_range(0, 7) << LEVEL_W) | lvl);
      end
   endtask

   initial begin : receiver
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            gap = HOLD_CYCLES;
         end else begin
            gap = rsp_calm ? 0 : $urandom_range(0, 17);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // checks results before noting pixels taken on the same edge
   initial begin : monitor
      int quiet;
      lane_result_t got;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset) begin
            quiet = 0;
         end else begin
            quiet++;
            if (rsp_valid && rsp_ready) begin
               got.column   = rsp_column;
               got.filtered = rsp_filtered;
               got.mark     = rsp_mark;
               got.row_end  = rsp_row_end;
               board.check_result(got);
               quiet = 0;
            end
            if (req_valid && req_ready) begin
               board.note_pixel(req_pixel);
               quiet = 0;
            end
            if (csr_valid && csr_ready) begin
               board.set_reg(csr_index, csr_data);
               quiet = 0;
            end
         end
      end
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin : stimulus
      int w, i;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // saturation both ways, zero centre, edge columns, tau clamped to half width
      write_reg(REG_IMAGE_WIDTH, 6);
      write_reg(REG_IMAGE_HEIGHT, 4);
      write_reg(REG_TAU_START, 1);
      write_reg(REG_TAU_FINAL, TAU_MAX_DEF);
      write_reg(REG_MARK_LEVEL, 0);
      for (i = 0; i < 24; i++) send_pixel(probe_pix[i]);
      drain();
      // zero width acts as one-pixel rows
      write_reg(REG_IMAGE_WIDTH, 0);
      send_pixel(8'd255);
      send_pixel(8'd0);
      drain();
      write_reg(REG_SPARE_LO, 11'h7FF);
      write_reg(REG_SPARE_HI, 11'h000);

      while (pixels_sent < STIM_ITEMS) begin
         drain();
         pick_config();
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         w = board.eff_width();
         case ($urandom_range(0, 7))
            0: begin
               // very wide row cut short by lowering the width mid-row
               write_reg(REG_IMAGE_WIDTH, $urandom_range(MAX_WIDTH_DEF, 2047));
               send_pixels($urandom_range(3, 30), 1'b0);
               drain();
               write_reg(REG_IMAGE_WIDTH, $urandom_range(1, board.col_cnt));
               send_pixels(1 + board.eff_width(), 1'b0);
            end
            1: begin
               // height lowered partway through a frame
               write_reg(REG_IMAGE_HEIGHT, $urandom_range(4, 8));
               send_pixels(board.rest_of_row() + w * $urandom_range(1, 3) + w / 2, 1'b0);
               drain();
               write_reg(REG_IMAGE_HEIGHT, $urandom_range(1, board.row_cnt + 1));
               send_pixels(board.rest_of_row() + w, 1'b0);
            end
            2:       send_pixels($urandom_range(1, 30), 1'b1);
            default: send_pixels(board.rest_of_row() + w * $urandom_range(1, 3), 1'b0);
         endcase
      end

      drain();
      if (board.col_cnt != 0) begin
         send_pixels(board.rest_of_row(), 1'b0);
         drain();
      end
      // one full 1024 row at the largest tau; receiver backs off while pixels keep coming
      write_reg(REG_IMAGE_WIDTH, 2047);
      write_reg(REG_IMAGE_HEIGHT, 1);
      write_reg(REG_TAU_START, TAU_MAX_DEF);
      write_reg(REG_TAU_FINAL, TAU_MAX_DEF);
      write_reg(REG_MARK_LEVEL, $urandom_range(0, 255));
      req_calm = 1'b1;
      rsp_calm = 1'b0;
      hold_off_req = 1'b1;
      send_pixels(MAX_WIDTH_DEF, 1'b0);

      drain();
      repeat (100) @(posedge clock);
      $display("tb_top: %0d pixels in, %0d results checked over %0d rows, %0d marks set",
               board.n_pixels, board.n_results, board.n_rows, board.n_marks);
      $display("tb_top: widths 1 to 1024, tau up to %0d, row-end bursts up to %0d results",
               board.max_tau, board.max_burst);
      if (board.errors == 0 && board.due.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
